>>> src/rsri_pkg.sv
// ----------------------------------------------------------------------------
// rsri_pkg
// Shared widths, codes and sideband types for the ray segment / ring
// intersection pipeline.
// ----------------------------------------------------------------------------
package rsri_pkg;

    localparam int COORD_W     = 32;
    localparam int DIR_W       = 16;
    localparam int LEN_W       = 31;
    localparam int RAD_W       = 31;
    localparam int DIR_FRAC    = 14;
    localparam int T_FRAC      = 16;
    localparam int Q_W         = COORD_W + 1;
    localparam int MD_W        = Q_W + DIR_W;
    localparam int QD_W        = MD_W + 1;
    localparam int SQ_W        = 2 * Q_W - 1;
    localparam int QQ_W        = SQ_W + 1;
    localparam int R2_W        = 2 * RAD_W;
    localparam int QH_W        = QD_W - 32;
    localparam int HH_W        = 2 * QH_W;
    localparam int HL_W        = QH_W + 33;
    localparam int LL_W        = 64;
    localparam int DISC_W      = 99;
    localparam int SQ_IN_W     = DISC_W - 1;
    localparam int ROOT_W      = 49;
    localparam int T_W         = 51;
    localparam int LIM_W       = LEN_W + DIR_FRAC;
    localparam int TP_W        = LIM_W;
    localparam int TD_W        = TP_W + 1 + DIR_W;
    localparam int P_W         = 63;
    localparam int NUM_W       = P_W - 1;
    localparam int DEN_W       = RAD_W + DIR_FRAC;
    localparam int QUO_W       = 17;
    localparam int FRAC_W      = 17;
    localparam int SQ_STAGES   = ROOT_W;
    localparam int DIV_STAGES  = QUO_W;
    localparam int PIPE_DEPTH  = 6 + SQ_STAGES + 6 + DIV_STAGES + 1;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [RAD_W-1:0]      INNER_RADIUS_RST = RAD_W'(32768);
    localparam logic [RAD_W-1:0]      OUTER_RADIUS_RST = RAD_W'(65536);
    localparam logic [QUO_W-1:0]      NORM_POS_LIM     = QUO_W'(32767);
    localparam logic [QUO_W-1:0]      NORM_NEG_LIM     = QUO_W'(32768);
    localparam logic signed [DIR_W-1:0] NORM_MAX       = 16'sh7fff;
    localparam logic signed [DIR_W-1:0] NORM_MIN       = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_INNER_RADIUS,
        REG_OUTER_RADIUS
    } cfg_reg_t;

    typedef struct packed {
        logic signed [Q_W-1:0]   qx;
        logic signed [Q_W-1:0]   qy;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic [LEN_W-1:0]        len;
        logic signed [QD_W-1:0]  qd;
        logic                    pos_o;
        logic                    pos_i;
    } sq_side_t;

    typedef struct packed {
        logic hit;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic den_zero;
    } dv_side_t;

    typedef struct packed {
        logic                    hit;
        logic [FRAC_W-1:0]       t_fraction;
        logic signed [DIR_W-1:0] normal_x;
        logic signed [DIR_W-1:0] normal_y;
    } result_t;

endpackage

>>> src/rsri_sqrt.sv
// ----------------------------------------------------------------------------
// rsri_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rsri_sqrt (
    input  logic                          clk,
    input  logic                          ce,
    input  logic [rsri_pkg::SQ_IN_W-1:0]  rad_in,
    output logic [rsri_pkg::ROOT_W-1:0]   root
);
    import rsri_pkg::*;

    logic [SQ_IN_W-1:0] rem_reg   [SQ_STAGES];
    logic [ROOT_W-1:0]  root_reg  [SQ_STAGES];
    logic [SQ_IN_W-1:0] rem_next  [SQ_STAGES];
    logic [ROOT_W-1:0]  root_next [SQ_STAGES];

    always_comb
    begin
        logic [SQ_IN_W-1:0] rem_src;
        logic [ROOT_W-1:0]  root_src;
        logic [SQ_IN_W:0]   trial;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            rem_src  = (k == 0) ? rad_in : rem_reg[(k == 0) ? 0 : k - 1];
            root_src = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k - 1];
            trial    = ((SQ_IN_W + 1)'(root_src) << (ROOT_W - k))
                     | ((SQ_IN_W + 1)'(1) << (2 * (ROOT_W - 1 - k)));
            if ({1'b0, rem_src} >= trial)
            begin
                rem_next[k]  = rem_src - trial[SQ_IN_W-1:0];
                root_next[k] = root_src | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_src;
                root_next[k] = root_src;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

>>> src/rsri_div.sv
// ----------------------------------------------------------------------------
// rsri_div
// Pipelined restoring divider, one quotient bit per stage; the quotient is
// valid when the numerator is below the divisor shifted by the quotient width.
// ----------------------------------------------------------------------------
module rsri_div (
    input  logic                        clk,
    input  logic                        ce,
    input  logic [rsri_pkg::NUM_W-1:0]  num,
    input  logic [rsri_pkg::DEN_W-1:0]  den,
    output logic [rsri_pkg::QUO_W-1:0]  quo
);
    import rsri_pkg::*;

    logic [NUM_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];

    always_comb
    begin
        logic [NUM_W-1:0] rem_src;
        logic [DEN_W-1:0] den_src;
        logic [QUO_W-1:0] quo_src;
        logic [NUM_W-1:0] dsh;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rem_src = (k == 0) ? num : rem_reg[(k == 0) ? 0 : k - 1];
            den_src = (k == 0) ? den : den_reg[(k == 0) ? 0 : k - 1];
            quo_src = (k == 0) ? '0 : quo_reg[(k == 0) ? 0 : k - 1];
            dsh     = NUM_W'(den_src) << (QUO_W - 1 - k);
            if (rem_src >= dsh)
            begin
                rem_next[k] = rem_src - dsh;
                quo_next[k] = quo_src | (QUO_W'(1) << (QUO_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_src;
                quo_next[k] = quo_src;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= rem_next[0];
            den_reg[0] <= den;
            quo_reg[0] <= quo_next[0];
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_reg[k-1];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

>>> src/ray_segment_ring_intersect.sv
// ----------------------------------------------------------------------------
// ray_segment_ring_intersect
// Intersects a stream of 2D ray segments with a configurable ring boundary
// and returns hit, t / length and the unit normal for each segment.
// ----------------------------------------------------------------------------
// One transaction enters per cycle while s_tready is high; the pipeline length
// comes mostly from the 49-stage square root (outer and inner roots run side by
// side) and the 17-stage dividers for t / length and the two normal components.
// An output register and one skid entry sit behind the pipeline, so s_tready
// drops only while the skid entry holds a transaction. Ring registers may be
// written only while no transaction is in flight.
module ray_segment_ring_intersect (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [rsri_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsri_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, dir_x, dir_y, seg_length, zero pad
    input  logic [rsri_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // t_fraction, normal_x, normal_y, zero pad
    output logic [rsri_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // hit
    output logic                                 m_tuser
);
    import rsri_pkg::*;

    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic [RAD_W-1:0]          inner_radius_reg;
    logic [RAD_W-1:0]          outer_radius_reg;

    logic                      ce;
    logic [PIPE_DEPTH-1:0]     vld_reg;

    logic signed [COORD_W-1:0] in_sx;
    logic signed [COORD_W-1:0] in_sy;

    // stage 1
    logic signed [Q_W-1:0]     s1_qx_reg, s1_qy_reg;
    logic signed [DIR_W-1:0]   s1_dx_reg, s1_dy_reg;
    logic [LEN_W-1:0]          s1_len_reg;
    // stage 2
    logic signed [MD_W-1:0]    s2_mx_reg, s2_my_reg;
    logic [SQ_W-1:0]           s2_sx_reg, s2_sy_reg;
    logic [R2_W-1:0]           s2_ro2_reg, s2_ri2_reg;
    logic signed [Q_W-1:0]     s2_qx_reg, s2_qy_reg;
    logic signed [DIR_W-1:0]   s2_dx_reg, s2_dy_reg;
    logic [LEN_W-1:0]          s2_len_reg;
    logic signed [2*Q_W-1:0]   sx_full, sy_full;
    // stage 3
    logic signed [QD_W-1:0]    s3_qd_reg;
    logic [QQ_W-1:0]           s3_qq_reg;
    logic [R2_W-1:0]           s3_ro2_reg, s3_ri2_reg;
    logic signed [Q_W-1:0]     s3_qx_reg, s3_qy_reg;
    logic signed [DIR_W-1:0]   s3_dx_reg, s3_dy_reg;
    logic [LEN_W-1:0]          s3_len_reg;
    // stage 4
    logic signed [HH_W-1:0]    s4_hh_reg;
    logic signed [HL_W-1:0]    s4_hl_reg;
    logic [LL_W-1:0]           s4_ll_reg;
    logic [QQ_W-1:0]           s4_qq_reg;
    logic [R2_W-1:0]           s4_ro2_reg, s4_ri2_reg;
    logic signed [QD_W-1:0]    s4_qd_reg;
    logic signed [Q_W-1:0]     s4_qx_reg, s4_qy_reg;
    logic signed [DIR_W-1:0]   s4_dx_reg, s4_dy_reg;
    logic [LEN_W-1:0]          s4_len_reg;
    logic signed [QH_W-1:0]    qd_hi;
    // stage 5
    logic signed [DISC_W-1:0]  s5_qdsq_reg;
    logic [QQ_W-1:0]           s5_qq_reg;
    logic [R2_W-1:0]           s5_ro2_reg, s5_ri2_reg;
    logic signed [QD_W-1:0]    s5_qd_reg;
    logic signed [Q_W-1:0]     s5_qx_reg, s5_qy_reg;
    logic signed [DIR_W-1:0]   s5_dx_reg, s5_dy_reg;
    logic [LEN_W-1:0]          s5_len_reg;
    // stage 6
    logic signed [DISC_W-1:0]  disc_o, disc_i, base;
    logic                      pos_o, pos_i;
    logic [SQ_IN_W-1:0]        s6_rad_o_reg, s6_rad_i_reg;
    sq_side_t                  s6_side_reg;
    sq_side_t                  sq_side_reg [SQ_STAGES];
    logic [ROOT_W-1:0]         root_o, root_i;
    // stage A
    logic signed [T_W-1:0]     sa_to_reg, sa_ti_reg;
    logic [LIM_W-1:0]          sa_lim_reg;
    sq_side_t                  sa_side_reg;
    sq_side_t                  sq_out;
    // stage B
    logic                      hit_o, hit_i;
    logic                      sb_hit_reg, sb_inner_reg;
    logic [TP_W-1:0]           sb_t_reg;
    logic [LIM_W-1:0]          sb_lim_reg;
    logic signed [Q_W-1:0]     sb_qx_reg, sb_qy_reg;
    logic signed [DIR_W-1:0]   sb_dx_reg, sb_dy_reg;
    // stage C
    logic signed [TD_W-1:0]    sc_tdx_reg, sc_tdy_reg;
    logic [RAD_W-1:0]          sc_rad_reg;
    logic                      sc_hit_reg, sc_inner_reg;
    logic [TP_W-1:0]           sc_t_reg;
    logic [LIM_W-1:0]          sc_lim_reg;
    logic signed [Q_W-1:0]     sc_qx_reg, sc_qy_reg;
    // stage D
    logic signed [P_W-1:0]     sd_px_reg, sd_py_reg;
    logic [RAD_W-1:0]          sd_rad_reg;
    logic                      sd_hit_reg, sd_inner_reg;
    logic [TP_W-1:0]           sd_t_reg;
    logic [LIM_W-1:0]          sd_lim_reg;
    // stage E
    logic [NUM_W-1:0]          se_pxm_reg, se_pym_reg, se_numt_reg;
    logic [DEN_W-1:0]          se_den_reg;
    logic [LIM_W-1:0]          se_lim_reg;
    logic                      se_hit_reg, se_neg_x_reg, se_neg_y_reg, se_dz_reg;
    logic signed [P_W-1:0]     px_neg, py_neg;
    // stage F
    logic [NUM_W-1:0]          sf_pxm_reg, sf_pym_reg, sf_numt_reg;
    logic [DEN_W-1:0]          sf_den_reg;
    logic [LIM_W-1:0]          sf_lim_reg;
    dv_side_t                  sf_side_reg;
    dv_side_t                  dv_side_reg [DIV_STAGES];
    logic [QUO_W-1:0]          quo_t, quo_x, quo_y;
    // stage G
    result_t                   res_next;
    result_t                   sg_res_reg;
    dv_side_t                  dv_out;
    // output
    result_t                   out_reg, skid_reg;
    logic                      out_valid_reg, skid_valid_reg;
    logic                      pipe_push;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            inner_radius_reg <= INNER_RADIUS_RST;
            outer_radius_reg <= OUTER_RADIUS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:     center_x_reg     <= cfg_data;
                REG_CENTER_Y:     center_y_reg     <= cfg_data;
                REG_INNER_RADIUS: inner_radius_reg <= cfg_data[RAD_W-1:0];
                REG_OUTER_RADIUS: outer_radius_reg <= cfg_data[RAD_W-1:0];
                default:          center_x_reg     <= center_x_reg;
            endcase
        end
    end

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
    end

    assign in_sx = s_tdata[31:0];
    assign in_sy = s_tdata[63:32];

    // datapath arithmetic
    always_comb
    begin
        sx_full = s1_qx_reg * s1_qx_reg;
        sy_full = s1_qy_reg * s1_qy_reg;
        qd_hi   = s3_qd_reg[QD_W-1:32];
        base    = s5_qdsq_reg - $signed(DISC_W'(s5_qq_reg) << (2 * DIR_FRAC));
        disc_o  = base + $signed(DISC_W'(s5_ro2_reg) << (2 * DIR_FRAC));
        disc_i  = base + $signed(DISC_W'(s5_ri2_reg) << (2 * DIR_FRAC));
        pos_o   = !disc_o[DISC_W-1] && (disc_o != '0);
        pos_i   = !disc_i[DISC_W-1] && (disc_i != '0);
        hit_o   = sa_side_reg.pos_o && !sa_to_reg[T_W-1] && (sa_to_reg != '0)
                && (sa_to_reg < $signed(T_W'(sa_lim_reg)));
        hit_i   = sa_side_reg.pos_o && sa_side_reg.pos_i && !sa_ti_reg[T_W-1]
                && (sa_ti_reg != '0) && (sa_ti_reg < $signed(T_W'(sa_lim_reg)));
        px_neg  = -sd_px_reg;
        py_neg  = -sd_py_reg;
    end

    assign sq_out = sq_side_reg[SQ_STAGES-1];
    assign dv_out = dv_side_reg[DIV_STAGES-1];

    always_comb
    begin
        res_next.hit        = dv_out.hit;
        res_next.t_fraction = dv_out.hit ? quo_t : '0;
        res_next.normal_x   = '0;
        res_next.normal_y   = '0;
        if (dv_out.hit && !dv_out.den_zero)
        begin
            if (dv_out.neg_x)
                res_next.normal_x = (dv_out.ovf_x || quo_x > NORM_NEG_LIM) ? NORM_MIN
                                  : -$signed(quo_x[DIR_W-1:0]);
            else
                res_next.normal_x = (dv_out.ovf_x || quo_x > NORM_POS_LIM) ? NORM_MAX
                                  : $signed(quo_x[DIR_W-1:0]);
            if (dv_out.neg_y)
                res_next.normal_y = (dv_out.ovf_y || quo_y > NORM_NEG_LIM) ? NORM_MIN
                                  : -$signed(quo_y[DIR_W-1:0]);
            else
                res_next.normal_y = (dv_out.ovf_y || quo_y > NORM_POS_LIM) ? NORM_MAX
                                  : $signed(quo_y[DIR_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // offset from center
            s1_qx_reg  <= Q_W'(in_sx) - Q_W'(center_x_reg);
            s1_qy_reg  <= Q_W'(in_sy) - Q_W'(center_y_reg);
            s1_dx_reg  <= s_tdata[79:64];
            s1_dy_reg  <= s_tdata[95:80];
            s1_len_reg <= s_tdata[126:96];
            // products
            s2_mx_reg  <= s1_qx_reg * s1_dx_reg;
            s2_my_reg  <= s1_qy_reg * s1_dy_reg;
            s2_sx_reg  <= sx_full[SQ_W-1:0];
            s2_sy_reg  <= sy_full[SQ_W-1:0];
            s2_ro2_reg <= outer_radius_reg * outer_radius_reg;
            s2_ri2_reg <= inner_radius_reg * inner_radius_reg;
            s2_qx_reg  <= s1_qx_reg;
            s2_qy_reg  <= s1_qy_reg;
            s2_dx_reg  <= s1_dx_reg;
            s2_dy_reg  <= s1_dy_reg;
            s2_len_reg <= s1_len_reg;
            // dot products
            s3_qd_reg  <= QD_W'(s2_mx_reg) + QD_W'(s2_my_reg);
            s3_qq_reg  <= QQ_W'(s2_sx_reg) + QQ_W'(s2_sy_reg);
            s3_ro2_reg <= s2_ro2_reg;
            s3_ri2_reg <= s2_ri2_reg;
            s3_qx_reg  <= s2_qx_reg;
            s3_qy_reg  <= s2_qy_reg;
            s3_dx_reg  <= s2_dx_reg;
            s3_dy_reg  <= s2_dy_reg;
            s3_len_reg <= s2_len_reg;
            // qd squared in partial products
            s4_hh_reg  <= qd_hi * qd_hi;
            s4_hl_reg  <= qd_hi * $signed({1'b0, s3_qd_reg[31:0]});
            s4_ll_reg  <= s3_qd_reg[31:0] * s3_qd_reg[31:0];
            s4_qq_reg  <= s3_qq_reg;
            s4_ro2_reg <= s3_ro2_reg;
            s4_ri2_reg <= s3_ri2_reg;
            s4_qd_reg  <= s3_qd_reg;
            s4_qx_reg  <= s3_qx_reg;
            s4_qy_reg  <= s3_qy_reg;
            s4_dx_reg  <= s3_dx_reg;
            s4_dy_reg  <= s3_dy_reg;
            s4_len_reg <= s3_len_reg;
            s5_qdsq_reg <= (DISC_W'(s4_hh_reg) <<< 64) + (DISC_W'(s4_hl_reg) <<< 33)
                         + $signed(DISC_W'(s4_ll_reg));
            s5_qq_reg  <= s4_qq_reg;
            s5_ro2_reg <= s4_ro2_reg;
            s5_ri2_reg <= s4_ri2_reg;
            s5_qd_reg  <= s4_qd_reg;
            s5_qx_reg  <= s4_qx_reg;
            s5_qy_reg  <= s4_qy_reg;
            s5_dx_reg  <= s4_dx_reg;
            s5_dy_reg  <= s4_dy_reg;
            s5_len_reg <= s4_len_reg;
            // discriminants
            s6_rad_o_reg      <= pos_o ? disc_o[SQ_IN_W-1:0] : '0;
            s6_rad_i_reg      <= pos_i ? disc_i[SQ_IN_W-1:0] : '0;
            s6_side_reg.qx    <= s5_qx_reg;
            s6_side_reg.qy    <= s5_qy_reg;
            s6_side_reg.dx    <= s5_dx_reg;
            s6_side_reg.dy    <= s5_dy_reg;
            s6_side_reg.len   <= s5_len_reg;
            s6_side_reg.qd    <= s5_qd_reg;
            s6_side_reg.pos_o <= pos_o;
            s6_side_reg.pos_i <= pos_i;
            sq_side_reg[0]    <= s6_side_reg;
            for (int k = 1; k < SQ_STAGES; k++)
                sq_side_reg[k] <= sq_side_reg[k-1];
            // candidate distances
            sa_to_reg   <= -T_W'(sq_out.qd) - $signed(T_W'(root_o));
            sa_ti_reg   <= -T_W'(sq_out.qd) + $signed(T_W'(root_i));
            sa_lim_reg  <= {sq_out.len, {DIR_FRAC{1'b0}}};
            sa_side_reg <= sq_out;
            // hit selection
            sb_hit_reg   <= hit_o || hit_i;
            sb_inner_reg <= !hit_o;
            sb_t_reg     <= hit_o ? sa_to_reg[TP_W-1:0] : sa_ti_reg[TP_W-1:0];
            sb_lim_reg   <= sa_lim_reg;
            sb_qx_reg    <= sa_side_reg.qx;
            sb_qy_reg    <= sa_side_reg.qy;
            sb_dx_reg    <= sa_side_reg.dx;
            sb_dy_reg    <= sa_side_reg.dy;
            // hit point
            sc_tdx_reg   <= $signed({1'b0, sb_t_reg}) * sb_dx_reg;
            sc_tdy_reg   <= $signed({1'b0, sb_t_reg}) * sb_dy_reg;
            sc_rad_reg   <= sb_inner_reg ? inner_radius_reg : outer_radius_reg;
            sc_hit_reg   <= sb_hit_reg;
            sc_inner_reg <= sb_inner_reg;
            sc_t_reg     <= sb_t_reg;
            sc_lim_reg   <= sb_lim_reg;
            sc_qx_reg    <= sb_qx_reg;
            sc_qy_reg    <= sb_qy_reg;
            sd_px_reg    <= (P_W'(sc_qx_reg) <<< (2 * DIR_FRAC)) + P_W'(sc_tdx_reg);
            sd_py_reg    <= (P_W'(sc_qy_reg) <<< (2 * DIR_FRAC)) + P_W'(sc_tdy_reg);
            sd_rad_reg   <= sc_rad_reg;
            sd_hit_reg   <= sc_hit_reg;
            sd_inner_reg <= sc_inner_reg;
            sd_t_reg     <= sc_t_reg;
            sd_lim_reg   <= sc_lim_reg;
            // divider operands
            se_pxm_reg   <= sd_px_reg[P_W-1] ? px_neg[NUM_W-1:0] : sd_px_reg[NUM_W-1:0];
            se_pym_reg   <= sd_py_reg[P_W-1] ? py_neg[NUM_W-1:0] : sd_py_reg[NUM_W-1:0];
            se_neg_x_reg <= sd_px_reg[P_W-1] ^ sd_inner_reg;
            se_neg_y_reg <= sd_py_reg[P_W-1] ^ sd_inner_reg;
            se_numt_reg  <= NUM_W'({sd_t_reg, {T_FRAC{1'b0}}});
            se_den_reg   <= {sd_rad_reg, {DIR_FRAC{1'b0}}};
            se_dz_reg    <= (sd_rad_reg == '0);
            se_hit_reg   <= sd_hit_reg;
            se_lim_reg   <= sd_lim_reg;
            sf_pxm_reg   <= se_pxm_reg;
            sf_pym_reg   <= se_pym_reg;
            sf_numt_reg  <= se_numt_reg;
            sf_den_reg   <= se_den_reg;
            sf_lim_reg   <= se_lim_reg;
            sf_side_reg.hit      <= se_hit_reg;
            sf_side_reg.neg_x    <= se_neg_x_reg;
            sf_side_reg.neg_y    <= se_neg_y_reg;
            sf_side_reg.ovf_x    <= se_pxm_reg >= {se_den_reg, {QUO_W{1'b0}}};
            sf_side_reg.ovf_y    <= se_pym_reg >= {se_den_reg, {QUO_W{1'b0}}};
            sf_side_reg.den_zero <= se_dz_reg;
            dv_side_reg[0] <= sf_side_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                dv_side_reg[k] <= dv_side_reg[k-1];
            // result
            sg_res_reg <= res_next;
        end
    end

    rsri_sqrt u_sqrt_outer (
        .clk    (clk),
        .ce     (ce),
        .rad_in (s6_rad_o_reg),
        .root   (root_o)
    );

    rsri_sqrt u_sqrt_inner (
        .clk    (clk),
        .ce     (ce),
        .rad_in (s6_rad_i_reg),
        .root   (root_i)
    );

    rsri_div u_div_t (
        .clk (clk),
        .ce  (ce),
        .num (sf_numt_reg),
        .den (sf_lim_reg),
        .quo (quo_t)
    );

    rsri_div u_div_x (
        .clk (clk),
        .ce  (ce),
        .num (sf_pxm_reg),
        .den (sf_den_reg),
        .quo (quo_x)
    );

    rsri_div u_div_y (
        .clk (clk),
        .ce  (ce),
        .num (sf_pym_reg),
        .den (sf_den_reg),
        .quo (quo_y)
    );

    // output register with one skid entry
    assign pipe_push = ce && vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (skid_valid_reg && (!out_valid_reg || m_tready))
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            if (pipe_push)
            begin
                if (!out_valid_reg || m_tready)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && (!out_valid_reg || m_tready))
            out_reg <= skid_reg;
        if (pipe_push)
        begin
            if (!out_valid_reg || m_tready)
                out_reg <= sg_res_reg;
            else
                skid_reg <= sg_res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = OUT_TDATA_W'({out_reg.normal_y, out_reg.normal_x, out_reg.t_fraction});

endmodule
